// ===== design/rotation_matrix_to_quaternion_unit_macros.svh =====
// Assertion macros for the rotation matrix to quaternion unit.
// Standalone header; taken in by the top level with an include.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define RMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rmq: implication check failed");
// next-cycle implication, disabled during reset
`define RMQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rmq: next-cycle check failed");
`else
`define RMQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RMQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/rmq_pkg.sv =====
// Shared constants for the rotation matrix to quaternion unit.
// No dependencies.
package rmq_pkg;

  localparam int unsigned WORD_BITS_DEF = 16;
  localparam int unsigned NUM_LANES     = 4;

  // lane order: quaternion components
  localparam int unsigned LANE_W = 0;
  localparam int unsigned LANE_X = 1;
  localparam int unsigned LANE_Y = 2;
  localparam int unsigned LANE_Z = 3;

endpackage

// ===== design/rotation_matrix_to_quaternion_unit.sv =====
// Rotation matrix to quaternion unit, top level.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_unit_macros.svh.
//
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one item: the nine matrix
//   entries r_*_i in signed Q2.(WORD_BITS-2). Output channel (out_valid_o /
//   out_ready_i) returns one item per input item: q_w_o (unsigned, never
//   negative) and signed q_x_o, q_y_o, q_z_o in the same format, in order.
//   Pipeline: one stage forms the four diagonal sums and the off-diagonal
//   signs, WORD_BITS-1 stages each settle one bit of the four square roots
//   side by side, and a last stage applies the signs. Throughput is one
//   item per cycle while the receiver keeps up (out_ready_i high).
//   Reset (rst_ni low, asynchronous) empties the pipeline; nothing is stored
//   beyond the items in flight.
//   Stall: when out_ready_i is low the output item holds; earlier stages keep
//   moving into empty slots, so bubbles are squeezed out, and in_ready_o drops
//   only once every stage holds an item. No item is lost or repeated.
//   in_ready_o depends combinationally on out_ready_i through the stage chain.
module rotation_matrix_to_quaternion_unit #(
  parameter int unsigned WORD_BITS = rmq_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [WORD_BITS-1:0] r_xx_i,
  input  logic signed [WORD_BITS-1:0] r_xy_i,
  input  logic signed [WORD_BITS-1:0] r_xz_i,
  input  logic signed [WORD_BITS-1:0] r_yx_i,
  input  logic signed [WORD_BITS-1:0] r_yy_i,
  input  logic signed [WORD_BITS-1:0] r_yz_i,
  input  logic signed [WORD_BITS-1:0] r_zx_i,
  input  logic signed [WORD_BITS-1:0] r_zy_i,
  input  logic signed [WORD_BITS-1:0] r_zz_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic        [WORD_BITS-2:0] q_w_o,
  output logic signed [WORD_BITS-1:0] q_x_o,
  output logic signed [WORD_BITS-1:0] q_y_o,
  output logic signed [WORD_BITS-1:0] q_z_o
);

  import rmq_pkg::*;

  `include "rotation_matrix_to_quaternion_unit_macros.svh"

  // widths
  localparam int unsigned SW  = WORD_BITS + 2;      // signed diagonal sum
  localparam int unsigned RTW = WORD_BITS - 1;      // root bits
  localparam int unsigned RB  = 2 * RTW;            // radicand bits
  localparam int unsigned RMW = WORD_BITS + 1;      // partial remainder
  localparam int unsigned NQ  = RTW;                // root stages
  localparam int unsigned NS  = NQ + 2;             // all stages
  localparam int unsigned SH  = WORD_BITS - 4;      // radicand = sum << (FRAC-2)

  localparam logic signed [SW-1:0] ONE_C = {{(SW-1){1'b0}}, 1'b1} << (WORD_BITS - 2);

  // one digit of the restoring square root
  function automatic logic [RMW+RTW-1:0] sq_step(input logic [RMW-1:0] rem,
                                                 input logic [RTW-1:0] root,
                                                 input logic [1:0]     pair);
    logic [RMW-1:0] cand;
    logic [RMW-1:0] trial;
    begin
      cand  = {rem[RMW-3:0], pair};
      trial = {root, 2'b01};
      if (cand >= trial) begin
        sq_step = {cand - trial, root[RTW-2:0], 1'b1};
      end else begin
        sq_step = {cand, root[RTW-2:0], 1'b0};
      end
    end
  endfunction

  // clamp a negative sum to zero, scale into radicand
  function automatic logic [RB-1:0] to_rad(input logic signed [SW-1:0] s);
    logic [RB-1:0] mag;
    begin
      mag = {{(RB-RMW){1'b0}}, s[RMW-1:0]};
      to_rad = s[SW-1] ? '0 : (mag << SH);
    end
  endfunction

  // stage valids and the load chain
  logic [NS-1:0] v_q;
  logic [NS-1:0] ld;

  always_comb begin
    ld[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  assign in_ready_o  = ld[0];
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // root pipeline payload, positions 0..NQ
  logic [RB-1:0]  rad_q  [NQ+1][NUM_LANES];
  logic [RMW-1:0] rem_q  [NQ+1][NUM_LANES];
  logic [RTW-1:0] root_q [NQ+1][NUM_LANES];
  logic [2:0]     neg_q  [NQ+1];   // signs of x, y, z

  // stage 0: diagonal sums and sign differences
  logic signed [SW-1:0]      xx_s, yy_s, zz_s;
  logic signed [SW-1:0]      sum_w, sum_x, sum_y, sum_z;
  logic signed [WORD_BITS:0] dif_x, dif_y, dif_z;

  always_comb begin
    xx_s  = {{2{r_xx_i[WORD_BITS-1]}}, r_xx_i};
    yy_s  = {{2{r_yy_i[WORD_BITS-1]}}, r_yy_i};
    zz_s  = {{2{r_zz_i[WORD_BITS-1]}}, r_zz_i};
    sum_w = ONE_C + xx_s + yy_s + zz_s;
    sum_x = ONE_C + xx_s - yy_s - zz_s;
    sum_y = ONE_C - xx_s + yy_s - zz_s;
    sum_z = ONE_C - xx_s - yy_s + zz_s;
    dif_x = {r_zy_i[WORD_BITS-1], r_zy_i} - {r_yz_i[WORD_BITS-1], r_yz_i};
    dif_y = {r_xz_i[WORD_BITS-1], r_xz_i} - {r_zx_i[WORD_BITS-1], r_zx_i};
    dif_z = {r_yx_i[WORD_BITS-1], r_yx_i} - {r_xy_i[WORD_BITS-1], r_xy_i};
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      rad_q[0][LANE_W] <= to_rad(sum_w);
      rad_q[0][LANE_X] <= to_rad(sum_x);
      rad_q[0][LANE_Y] <= to_rad(sum_y);
      rad_q[0][LANE_Z] <= to_rad(sum_z);
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_q[0][l]  <= '0;
        root_q[0][l] <= '0;
      end
      neg_q[0] <= {dif_z[WORD_BITS], dif_y[WORD_BITS], dif_x[WORD_BITS]};
    end
  end

  // stages 1..NQ: one root bit per stage, four lanes side by side
  for (genvar k = 1; k <= NQ; k++) begin : g_root
    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          {rem_q[k][l], root_q[k][l]} <= sq_step(rem_q[k-1][l], root_q[k-1][l],
                                                 rad_q[k-1][l][RB-1:RB-2]);
          rad_q[k][l] <= rad_q[k-1][l] << 2;
        end
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // output stage: apply signs
  logic [WORD_BITS-1:0] mag_x, mag_y, mag_z;

  assign mag_x = {1'b0, root_q[NQ][LANE_X]};
  assign mag_y = {1'b0, root_q[NQ][LANE_Y]};
  assign mag_z = {1'b0, root_q[NQ][LANE_Z]};

  always_ff @(posedge clk_i) begin
    if (ld[NS-1]) begin
      q_w_o <= root_q[NQ][LANE_W];
      q_x_o <= neg_q[NQ][0] ? (~mag_x + {{(WORD_BITS-1){1'b0}}, 1'b1}) : mag_x;
      q_y_o <= neg_q[NQ][1] ? (~mag_y + {{(WORD_BITS-1){1'b0}}, 1'b1}) : mag_y;
      q_z_o <= neg_q[NQ][2] ? (~mag_z + {{(WORD_BITS-1){1'b0}}, 1'b1}) : mag_z;
    end
  end

  // checks
  // an empty output slot must let the input side through
  `RMQ_ASSERT_IMP(a_empty_out_ready, clk_i, rst_ni, !out_valid_o, in_ready_o)
  // the input only backs up when the pipe is full and the receiver stalls
  `RMQ_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i && (&v_q))
  // a taken item in the slot before the output always lands in the output
  `RMQ_ASSERT_NXT(a_advance, clk_i, rst_ni, v_q[NS-2] && ld[NS-1], out_valid_o)

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for rotation_matrix_to_quaternion_unit.
// Needs rmq_pkg and the unit's RTL. A scoreboard class predicts each
// quaternion, and plain tasks drive the valid/ready channels.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned WB   = rmq_pkg::WORD_BITS_DEF;
  localparam int unsigned FRAC = WB - 2;
  localparam longint      ONE  = longint'(1) << FRAC;
  localparam longint      MAXV = (longint'(1) << (WB - 1)) - 1;
  localparam longint      MINV = -(longint'(1) << (WB - 1));
  localparam int unsigned LAT  = WB;       // acceptance to out_valid_o, no stall

  // one input item: the nine matrix entries, row-major
  typedef struct packed {
    logic signed [WB-1:0] xx, xy, xz;
    logic signed [WB-1:0] yx, yy, yz;
    logic signed [WB-1:0] zx, zy, zz;
  } matrix_t;

  // one result item
  typedef struct packed {
    logic        [WB-2:0] w;
    logic signed [WB-1:0] x, y, z;
  } quat_t;

  // floor(sqrt(n)), one result bit per trial from the top down
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root, cand;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  // sqrt(sum)/2 in Q2.FRAC, negative sums clamped to nothing
  function automatic longint unsigned half_root(longint sum);
    if (sum <= 0) return 0;
    return floor_root(longint'(unsigned'(sum)) << (FRAC - 2));
  endfunction

  function automatic logic signed [WB-1:0] signed_part(longint unsigned mag, bit neg);
    longint v;
    v = neg ? -longint'(mag) : longint'(mag);
    return v[WB-1:0];
  endfunction

  class quat_scoreboard;
    quat_t       expected_q[$];
    int unsigned matrices_seen;
    int unsigned quats_checked;
    int unsigned faults;

    function quat_t predict_quat(matrix_t m);
      longint sw, sx, sy, sz;
      quat_t  q;
      sw = ONE + m.xx + m.yy + m.zz;
      sx = ONE + m.xx - m.yy - m.zz;
      sy = ONE - m.xx + m.yy - m.zz;
      sz = ONE - m.xx - m.yy + m.zz;
      q.w = (WB - 1)'(half_root(sw));
      // signs follow the off-diagonal differences; a zero difference keeps +
      q.x = signed_part(half_root(sx), (longint'(m.zy) - longint'(m.yz)) < 0);
      q.y = signed_part(half_root(sy), (longint'(m.xz) - longint'(m.zx)) < 0);
      q.z = signed_part(half_root(sz), (longint'(m.yx) - longint'(m.xy)) < 0);
      return q;
    endfunction

    function void note_matrix(matrix_t m);
      expected_q.push_back(predict_quat(m));
      matrices_seen++;
    endfunction

    function void flag(string what, longint want, longint got);
      // keep the log bounded if the unit is badly broken
      if (faults < 100)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      else if (faults == 100)
        $display("%0t: further mismatches not shown", $time);
      faults++;
    endfunction

    function void check_quat(quat_t got);
      quat_t want;
      quats_checked++;
      if (expected_q.size() == 0) begin
        flag("unexpected quaternion, q_x", 0, got.x);
        return;
      end
      want = expected_q.pop_front();
      if (got.w !== want.w) flag("q_w", longint'(want.w), longint'(got.w));
      if (got.x !== want.x) flag("q_x", want.x, got.x);
      if (got.y !== want.y) flag("q_y", want.y, got.y);
      if (got.z !== want.z) flag("q_z", want.z, got.z);
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    out_ready_i = 1'b0;
  matrix_t tx_m        = '0;
  logic    in_ready_o, out_valid_o;
  quat_t   rx_q;
  int      rx_mode     = 0;    // 0 always ready, 1 light stalls, 2 heavy stalls

  quat_scoreboard sb;

  rotation_matrix_to_quaternion_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .r_xx_i      (tx_m.xx),
    .r_xy_i      (tx_m.xy),
    .r_xz_i      (tx_m.xz),
    .r_yx_i      (tx_m.yx),
    .r_yy_i      (tx_m.yy),
    .r_yz_i      (tx_m.yz),
    .r_zx_i      (tx_m.zx),
    .r_zy_i      (tx_m.zy),
    .r_zz_i      (tx_m.zz),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .q_w_o       (rx_q.w),
    .q_x_o       (rx_q.x),
    .q_y_o       (rx_q.y),
    .q_z_o       (rx_q.z)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both channels are sampled at the edge, before any of this edge's
  // nonblocking updates land, so ordering within the step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_matrix(tx_m);
      if (out_valid_o && out_ready_i) sb.check_quat(rx_q);
    end
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: ready in runs, broken by stalls whose rate follows rx_mode.
  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ((rx_mode == 1 && $urandom_range(0, 3) == 0) ||
          (rx_mode == 2 && $urandom_range(0, 1) == 0)) begin
        out_ready_i <= 1'b0;
        repeat (1 + pick_idle()) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  function automatic matrix_t make_matrix(longint xx, longint xy, longint xz,
                                          longint yx, longint yy, longint yz,
                                          longint zx, longint zy, longint zz);
    matrix_t m;
    m.xx = xx[WB-1:0]; m.xy = xy[WB-1:0]; m.xz = xz[WB-1:0];
    m.yx = yx[WB-1:0]; m.yy = yy[WB-1:0]; m.yz = yz[WB-1:0];
    m.zx = zx[WB-1:0]; m.zy = zy[WB-1:0]; m.zz = zz[WB-1:0];
    return m;
  endfunction

  // Random item: raw words, entries in the rotation range, or corner values.
  function automatic matrix_t random_matrix();
    matrix_t m;
    longint  v;
    int      kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      if (kind < 4) begin
        v = longint'($urandom);
      end else if (kind < 8) begin
        v = longint'($urandom_range(0, 2 * ONE)) - ONE;
      end else begin
        case ($urandom_range(0, 7))
          0: v = MINV;
          1: v = MAXV;
          2: v = 0;
          3: v = ONE;
          4: v = -ONE;
          5: v = 1;
          6: v = -1;
          default: v = longint'($urandom);
        endcase
      end
      m[k*WB +: WB] = v[WB-1:0];
    end
    return m;
  endfunction

  // Presents one item and returns at the edge that accepts it; valid stays
  // high so the caller can follow straight on with the next item.
  task automatic drive_matrix(input matrix_t m);
    in_valid_i <= 1'b1;
    tx_m       <= m;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random(input int unsigned count, input bit with_gaps);
    int unsigned g;
    for (int unsigned n = 0; n < count; n++) begin
      drive_matrix(random_matrix());
      if (with_gaps) begin
        g = pick_idle();
        if (g != 0) begin
          in_valid_i <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  initial begin
    matrix_t directed_q[$];

    sb = new;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity, all zero, both word extremes everywhere
    directed_q.push_back(make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    directed_q.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_matrix(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    directed_q.push_back(make_matrix(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
    // half turns: w clamps to zero, one of x/y/z carries the whole
    directed_q.push_back(make_matrix(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
    directed_q.push_back(make_matrix(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
    directed_q.push_back(make_matrix(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE));
    // quarter turns either way about each axis: sign from each difference
    directed_q.push_back(make_matrix(ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0));
    directed_q.push_back(make_matrix(ONE, 0, 0, 0, 0, ONE, 0, -ONE, 0));
    directed_q.push_back(make_matrix(0, 0, ONE, 0, ONE, 0, -ONE, 0, 0));
    directed_q.push_back(make_matrix(0, 0, -ONE, 0, ONE, 0, ONE, 0, 0));
    directed_q.push_back(make_matrix(0, -ONE, 0, ONE, 0, 0, 0, 0, ONE));
    directed_q.push_back(make_matrix(0, ONE, 0, -ONE, 0, 0, 0, 0, ONE));
    // most negative diagonal, then the x sum at its largest: w clamped in both
    directed_q.push_back(make_matrix(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV));
    directed_q.push_back(make_matrix(MAXV, MINV, MINV, MINV, MINV, MINV, MAXV, MAXV, MINV));
    // extreme differences of both signs and a zero difference
    directed_q.push_back(make_matrix(MAXV, MINV, MINV, MINV, MAXV, MINV, MAXV, MAXV, MAXV));
    // smallest negative differences
    directed_q.push_back(make_matrix(0, 0, 5, -1, 0, 1, 6, 0, 0));
    // sums exactly zero, then just below zero
    directed_q.push_back(make_matrix(-ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(make_matrix(-ONE - 1, 0, 0, 0, 0, 0, 0, 0, 0));
    // alternating bit patterns
    directed_q.push_back(make_matrix(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                     16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    directed_q.push_back(make_matrix(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                     16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));

    foreach (directed_q[k]) drive_matrix(directed_q[k]);

    // random with gaps on both sides
    rx_mode = 1;
    send_random(500, 1'b1);

    // sender holds off until the pipeline has emptied
    in_valid_i <= 1'b0;
    wait_drained();

    // back-to-back stretch, no idling anywhere
    rx_mode = 0;
    send_random(250, 1'b0);

    // heavy back-pressure so the pipeline fills and in_ready_o drops
    rx_mode = 2;
    send_random(500, 1'b1);
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (3 * LAT) @(posedge clk_i);
    if (sb.expected_q.size() != 0) sb.flag("quaternions missing, count", 0,
                                           sb.expected_q.size());

    $display("Summary: %0d matrices sent, %0d quaternions compared, %0d mismatches.",
             sb.matrices_seen, sb.quats_checked, sb.faults);
    $display("Covered identity, half and quarter turns, clamped sums, word extremes, %s",
             "random entries under gaps, back-pressure and a full drain.");
    if (sb.faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // generous ceiling, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("Timed out with %0d quaternions outstanding.", sb.expected_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/rmq_pkg.sv
design/rotation_matrix_to_quaternion_unit.sv
sim/tb.sv
